/* hw/rtl/nra_pkg.sv */
// ----------------------------------------------------------------------------
// nra_pkg
// Shared widths, codes and request/response types of the nearest-neighbor
// resize address generator.
// ----------------------------------------------------------------------------
package nra_pkg;

  localparam int DIM_W      = 13;
  localparam int PITCH_W    = 16;
  localparam int COORD_W    = 12;
  localparam int OFF_W      = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  // The error terms can grow past the image size when the dimensions are
  // rewritten during a strip, so they carry extra headroom.
  localparam int ERR_W      = 27;
  localparam int DIV_CNT_W  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH     = 3'd0,
    REG_SRC_HEIGHT    = 3'd1,
    REG_DST_WIDTH     = 3'd2,
    REG_DST_HEIGHT    = 3'd3,
    REG_SRC_ROW_PITCH = 3'd4,
    REG_DST_ROW_PITCH = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             start;
    logic [DIM_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIM_W-1:0] quotient;
    logic [DIM_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic               en;
    logic [COORD_W-1:0] a;
    logic [PITCH_W-1:0] b;
    logic [OFF_W-1:0]   addend;
  } mac_req_t;

endpackage

/* hw/rtl/nra_ifs.sv */
// ----------------------------------------------------------------------------
// nra_ifs
// Valid/ready channels of the resize address generator: the command channel
// and the pixel address channel.
// ----------------------------------------------------------------------------
interface nra_in_if;
  import nra_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [COORD_W-1:0] start_row;
  logic [DIM_W-1:0]   row_count;

  modport source (output valid, output command, output start_row, output row_count,
                  input ready);
  modport sink   (input valid, input command, input start_row, input row_count,
                  output ready);
endinterface

interface nra_out_if;
  import nra_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] source_x;
  logic [COORD_W-1:0] source_y;
  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_row;
  logic [OFF_W-1:0]   source_offset;
  logic [OFF_W-1:0]   dest_offset;
  logic               row_end;
  logic               strip_end;

  modport source (output valid, output source_x, output source_y, output dest_x,
                  output dest_row, output source_offset, output dest_offset,
                  output row_end, output strip_end, input ready);
  modport sink   (input valid, input source_x, input source_y, input dest_x,
                  input dest_row, input source_offset, input dest_offset,
                  input row_end, input strip_end, output ready);
endinterface

/* hw/rtl/nra_divider.sv */
// ----------------------------------------------------------------------------
// nra_divider
// Restoring divider that produces one quotient bit per cycle and returns the
// quotient and remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module nra_divider
  import nra_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIM_W-1:0]     rem_q;
  logic [DIM_W-1:0]     dvd_q;
  logic [DIM_W-1:0]     dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DIM_W:0]   shifted;
  logic [DIM_W:0]   diff;
  logic             ge;

  assign shifted = {rem_q, dvd_q[DIM_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        dvd_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
        dvd_q <= {dvd_q[DIM_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* hw/rtl/nra_mac.sv */
// ----------------------------------------------------------------------------
// nra_mac
// Registered multiply-add that forms a byte offset as row times pitch plus
// a column term.
// ----------------------------------------------------------------------------
module nra_mac
  import nra_pkg::*;
(
  input  logic             clk_i,
  input  mac_req_t         req_i,
  output logic [OFF_W-1:0] result_o
);

  logic [OFF_W-1:0] prod;
  logic [OFF_W-1:0] result_q;

  assign prod = {{PITCH_W{1'b0}}, req_i.a} * {{COORD_W{1'b0}}, req_i.b};

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      result_q <= prod + req_i.addend;
    end
  end

  assign result_o = result_q;

endmodule

/* hw/rtl/nearest_resize_address_gen_unit.sv */
// ----------------------------------------------------------------------------
// nearest_resize_address_gen_unit
// Source and destination address generator for a nearest-neighbor RGB24
// resize that samples at destination pixel centers.
//
// Commands arrive on in_if. A start command (command 0) checks the image
// dimensions and the strip and, if they pass, clamps the row count, runs
// four divisions on the shared divider and then steps the row DDA once per
// cycle up to the first row, with no result.
// A next command (command 1) on an active strip gives one pixel on out_if:
// the shared multiply-add forms the source offset and then the destination
// offset, and the output state updates the DDA state. A next command with no
// active strip gives nothing. in_if.ready is high only while the sequencer
// waits for a command, so the block takes no new command until it is through
// with the last one. A finished pixel waits in the output register; the
// block takes the next command meanwhile and stalls only when a second pixel
// is ready before out_if has taken the first. Configuration registers are
// written through cfg_we_i at any time. Reset restores the register defaults
// and leaves no strip active.
// ----------------------------------------------------------------------------
module nearest_resize_address_gen_unit
  import nra_pkg::*;
#(
  parameter int MAX_DIM         = 4096,
  parameter int BYTES_PER_PIXEL = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  nra_in_if.sink                in_if,
  nra_out_if.source             out_if
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FFWD,
    ST_MUL_SRC,
    ST_MUL_DST,
    ST_OUT
  } state_e;

  logic [DIM_W-1:0]   src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [PITCH_W-1:0] src_pitch_q, dst_pitch_q;

  state_e             state_q;
  logic               strip_active_q;
  logic               div_start_q;
  logic [1:0]         div_idx_q;
  logic [COORD_W-1:0] ffwd_cnt_q;

  logic [COORD_W-1:0] col_src_q, col_src_start_q, row_src_q;
  logic [COORD_W-1:0] col_quo_q, row_quo_q;
  logic [DIM_W-1:0]   col_rem_q, row_rem_q;
  logic [ERR_W-1:0]   col_err_q, col_err_start_q, row_err_q;
  logic [DIM_W-1:0]   dest_col_q;
  logic [COORD_W-1:0] dest_line_q;
  logic [DIM_W-1:0]   rows_left_q;
  logic [OFF_W-1:0]   src_off_q;

  logic               out_valid_q;
  logic [COORD_W-1:0] out_src_x_q, out_src_y_q, out_dst_x_q, out_dst_row_q;
  logic [OFF_W-1:0]   out_src_off_q, out_dst_off_q;
  logic               out_row_end_q, out_strip_end_q;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  mac_req_t           mac_req;
  logic [OFF_W-1:0]   mac_result;

  logic               start_ok;
  logic [DIM_W-1:0]   rows_avail;
  logic [DIM_W-1:0]   rows_clamped;
  logic [ERR_W-1:0]   row_sum, row_err_nx, col_sum, col_err_nx;
  logic               row_wrap, col_wrap;
  logic [COORD_W-1:0] row_src_nx, col_src_nx;
  logic               row_end, strip_end;
  logic [DIM_W-1:0]   rows_left_nx;
  logic [COORD_W-1:0] mac_col;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (32'(d) <= 32'(MAX_DIM));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= DIM_W'(1);
      src_height_q <= DIM_W'(1);
      dst_width_q  <= DIM_W'(1);
      dst_height_q <= DIM_W'(1);
      src_pitch_q  <= PITCH_W'(3);
      dst_pitch_q  <= PITCH_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_WIDTH:     src_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_SRC_HEIGHT:    src_height_q <= cfg_data_i[DIM_W-1:0];
        REG_DST_WIDTH:     dst_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_DST_HEIGHT:    dst_height_q <= cfg_data_i[DIM_W-1:0];
        REG_SRC_ROW_PITCH: src_pitch_q  <= cfg_data_i;
        REG_DST_ROW_PITCH: dst_pitch_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    start_ok = dim_ok(src_width_q) && dim_ok(src_height_q) &&
               dim_ok(dst_width_q) && dim_ok(dst_height_q) &&
               ({1'b0, in_if.start_row} < dst_height_q) && (in_if.row_count != '0);
    rows_avail   = dst_height_q - {1'b0, in_if.start_row};
    rows_clamped = (in_if.row_count > rows_avail) ? rows_avail : in_if.row_count;
  end

  always_comb begin
    div_req.start = div_start_q;
    case (div_idx_q)
      2'd0:    div_req.dividend = src_width_q;
      2'd1:    div_req.dividend = src_width_q >> 1;
      2'd2:    div_req.dividend = src_height_q;
      default: div_req.dividend = src_height_q >> 1;
    endcase
    div_req.divisor = div_idx_q[1] ? dst_height_q : dst_width_q;
  end

  always_comb begin
    row_sum    = row_err_q + ERR_W'(row_rem_q);
    row_wrap   = row_sum >= ERR_W'(dst_height_q);
    row_err_nx = row_wrap ? row_sum - ERR_W'(dst_height_q) : row_sum;
    row_src_nx = row_src_q + row_quo_q + COORD_W'(row_wrap);

    col_sum    = col_err_q + ERR_W'(col_rem_q);
    col_wrap   = col_sum >= ERR_W'(dst_width_q);
    col_err_nx = col_wrap ? col_sum - ERR_W'(dst_width_q) : col_sum;
    col_src_nx = col_src_q + col_quo_q + COORD_W'(col_wrap);

    row_end      = ({1'b0, dest_col_q} + 1'b1) >= {1'b0, dst_width_q};
    strip_end    = row_end && (rows_left_q <= DIM_W'(1));
    rows_left_nx = (rows_left_q != '0) ? rows_left_q - 1'b1 : rows_left_q;
  end

  always_comb begin
    mac_req.en = (state_q == ST_MUL_SRC) || (state_q == ST_MUL_DST);
    if (state_q == ST_MUL_SRC) begin
      mac_req.a = row_src_q;
      mac_req.b = src_pitch_q;
      mac_col   = col_src_q;
    end else begin
      mac_req.a = dest_line_q;
      mac_req.b = dst_pitch_q;
      mac_col   = dest_col_q[COORD_W-1:0];
    end
    mac_req.addend = OFF_W'(mac_col * BYTES_PER_PIXEL);
  end

  nra_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  nra_mac u_mac (
    .clk_i    (clk_i),
    .req_i    (mac_req),
    .result_o (mac_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      strip_active_q  <= 1'b0;
      div_start_q     <= 1'b0;
      div_idx_q       <= '0;
      ffwd_cnt_q      <= '0;
      col_src_q       <= '0;
      col_src_start_q <= '0;
      row_src_q       <= '0;
      col_quo_q       <= '0;
      row_quo_q       <= '0;
      col_rem_q       <= '0;
      row_rem_q       <= '0;
      col_err_q       <= '0;
      col_err_start_q <= '0;
      row_err_q       <= '0;
      dest_col_q      <= '0;
      dest_line_q     <= '0;
      rows_left_q     <= '0;
      src_off_q       <= '0;
      out_valid_q     <= 1'b0;
      out_src_x_q     <= '0;
      out_src_y_q     <= '0;
      out_dst_x_q     <= '0;
      out_dst_row_q   <= '0;
      out_src_off_q   <= '0;
      out_dst_off_q   <= '0;
      out_row_end_q   <= 1'b0;
      out_strip_end_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_if.valid) begin
            if (in_if.command == CMD_START) begin
              strip_active_q <= 1'b0;
              if (start_ok) begin
                rows_left_q <= rows_clamped;
                ffwd_cnt_q  <= in_if.start_row;
                div_idx_q   <= '0;
                div_start_q <= 1'b1;
                state_q     <= ST_DIV;
              end
            end else if (strip_active_q) begin
              state_q <= ST_MUL_SRC;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            case (div_idx_q)
              2'd0: begin
                col_quo_q <= div_rsp.quotient[COORD_W-1:0];
                col_rem_q <= div_rsp.remainder;
              end
              2'd1: begin
                col_src_start_q <= div_rsp.quotient[COORD_W-1:0];
                col_err_start_q <= ERR_W'(div_rsp.remainder);
              end
              2'd2: begin
                row_quo_q <= div_rsp.quotient[COORD_W-1:0];
                row_rem_q <= div_rsp.remainder;
              end
              default: begin
                row_src_q <= div_rsp.quotient[COORD_W-1:0];
                row_err_q <= ERR_W'(div_rsp.remainder);
              end
            endcase
            if (div_idx_q == 2'd3) begin
              state_q <= ST_FFWD;
            end else begin
              div_idx_q   <= div_idx_q + 1'b1;
              div_start_q <= 1'b1;
            end
          end
        end
        ST_FFWD: begin
          if (ffwd_cnt_q != '0) begin
            row_src_q  <= row_src_nx;
            row_err_q  <= row_err_nx;
            ffwd_cnt_q <= ffwd_cnt_q - 1'b1;
          end else begin
            col_src_q      <= col_src_start_q;
            col_err_q      <= col_err_start_q;
            dest_col_q     <= '0;
            dest_line_q    <= '0;
            strip_active_q <= 1'b1;
            state_q        <= ST_IDLE;
          end
        end
        ST_MUL_SRC: begin
          state_q <= ST_MUL_DST;
        end
        ST_MUL_DST: begin
          src_off_q <= mac_result;
          state_q   <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q     <= 1'b1;
            out_src_x_q     <= col_src_q;
            out_src_y_q     <= row_src_q;
            out_dst_x_q     <= dest_col_q[COORD_W-1:0];
            out_dst_row_q   <= dest_line_q;
            out_src_off_q   <= src_off_q;
            out_dst_off_q   <= mac_result;
            out_row_end_q   <= row_end;
            out_strip_end_q <= strip_end;
            if (!row_end) begin
              col_src_q  <= col_src_nx;
              col_err_q  <= col_err_nx;
              dest_col_q <= dest_col_q + 1'b1;
            end else begin
              col_src_q   <= col_src_start_q;
              col_err_q   <= col_err_start_q;
              dest_col_q  <= '0;
              row_src_q   <= row_src_nx;
              row_err_q   <= row_err_nx;
              dest_line_q <= dest_line_q + 1'b1;
              rows_left_q <= rows_left_nx;
              if (rows_left_nx == '0) begin
                strip_active_q <= 1'b0;
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready          = (state_q == ST_IDLE);
  assign out_if.valid         = out_valid_q;
  assign out_if.source_x      = out_src_x_q;
  assign out_if.source_y      = out_src_y_q;
  assign out_if.dest_x        = out_dst_x_q;
  assign out_if.dest_row      = out_dst_row_q;
  assign out_if.source_offset = out_src_off_q;
  assign out_if.dest_offset   = out_dst_off_q;
  assign out_if.row_end       = out_row_end_q;
  assign out_if.strip_end     = out_strip_end_q;

endmodule

/* hw/rtl/nra_checker.sv */
// ----------------------------------------------------------------------------
// nra_checker
// Port-level checks of the resize address generator, bound to the top level.
// ----------------------------------------------------------------------------
module nra_checker
  import nra_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] out_dest_x,
  input logic [OFF_W-1:0]   out_source_offset,
  input logic [OFF_W-1:0]   out_dest_offset,
  input logic               out_row_end,
  input logic               out_strip_end
);

  // A stalled pixel keeps its destination column, both offsets and its strip end flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_dest_x) && $stable(out_source_offset) &&
                                $stable(out_dest_offset) && $stable(out_strip_end))
    else $error("stalled pixel payload changed");

  // The last pixel of a strip is always the last pixel of its row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_strip_end |-> out_row_end)
    else $error("strip end without row end");

  // A new pixel appears only as the sequencer returns to wait for a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> in_ready)
    else $error("pixel shown while the sequencer is busy");

  // The sequencer leaves its wait state only after a command transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready) |-> $past(in_valid))
    else $error("busy without a command transfer");

endmodule

bind nearest_resize_address_gen_unit nra_checker u_nra_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_dest_x        (out_if.dest_x),
  .out_source_offset (out_if.source_offset),
  .out_dest_offset   (out_if.dest_offset),
  .out_row_end       (out_if.row_end),
  .out_strip_end     (out_if.strip_end)
);
